/* rtl/tw_pkg.sv */
// Shared types and constants for the text wrap layout and hit test block.
// Used by tw_cfg, tw_core and the top level; depends on nothing else.
`timescale 1ns / 1ps

package tw_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 96;
    localparam int HIT_INDEX_W = 11;
    localparam int COORD_W     = 16;
    localparam int POS_W       = 18;

    localparam logic [7:0] LINE_HEIGHT_RST = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_HEIGHT = 3'd0,
        REG_WRAP_WIDTH  = 3'd1,
        REG_QUERY_X     = 3'd2,
        REG_QUERY_Y     = 3'd3,
        REG_ORIGIN_X    = 3'd4,
        REG_ORIGIN_Y    = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [7:0]                line_height;
        logic [COORD_W-1:0]        wrap_width;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic       is_newline;
        logic [7:0] glyph_width;
        logic       last;
    } item_t;

    typedef struct packed {
        logic                    glyph_valid;
        logic signed [POS_W-1:0] glyph_x;
        logic signed [POS_W-1:0] glyph_y;
        logic [COORD_W-1:0]      extent_width;
        logic [COORD_W-1:0]      extent_height;
        logic [COORD_W-1:0]      end_x;
        logic                    hit_found;
        logic [HIT_INDEX_W-1:0]  hit_index;
        logic                    last_out;
    } result_t;

endpackage

/* rtl/text_wrap_layout_and_hit_test_top.sv */
// Top level of the text wrap layout and hit test block: stream ports and pipeline registers.
// Depends on tw_pkg, tw_cfg and tw_core.
`timescale 1ns / 1ps

// Takes one character per beat and returns one result beat per character. A beat waits
// in the input register while the layout core updates its state, then moves to the
// result register, which offers it on the output; a new character is taken every cycle
// while the output side does not stall. The sustained rate of one beat per cycle, when
// the output does not stall, is set by the layout core's state update, which the next
// character needs. Both registers hold while the output side stalls.
// The beat with tlast set carries the string totals, and the layout state returns to
// its start afterward.

module text_wrap_layout_and_hit_test_top
#(
    parameter int MAX_CHARS = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // glyph_width [7:0]
    input  logic [tw_pkg::S_DATA_W-1:0]   s_tdata,
    // is_newline [0]
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // glyph_x [17:0], glyph_y [35:18], extent_width [51:36], extent_height [67:52],
    // end_x [83:68], hit_found [84], hit_index [95:85]
    output logic [tw_pkg::M_DATA_W-1:0]   m_tdata,
    // glyph_valid [0]
    output logic                          m_tuser,
    output logic                          m_tlast
);

    tw_pkg::cfg_t    cfg;
    tw_pkg::item_t   in_item_reg;
    tw_pkg::result_t step_result;
    tw_pkg::result_t out_reg;
    logic            in_vld_reg, in_vld_next;
    logic            out_vld_reg, out_vld_next;
    logic            s_accept;
    logic            advance;

    tw_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tw_core
    #(
        .MAX_CHARS (MAX_CHARS)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || !out_vld_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.is_newline  <= s_tuser;
            in_item_reg.glyph_width <= s_tdata;
            in_item_reg.last        <= s_tlast;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.glyph_valid;
    assign m_tlast  = out_reg.last_out;
    assign m_tdata  = {out_reg.hit_index, out_reg.hit_found, out_reg.end_x,
                       out_reg.extent_height, out_reg.extent_width,
                       out_reg.glyph_y, out_reg.glyph_x};

endmodule

/* rtl/tw_cfg.sv */
// Configuration register file for the text wrap layout block.
// Depends on tw_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module tw_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tw_pkg::CFG_DATA_W-1:0] cfg_data,
    output tw_pkg::cfg_t                  cfg
);

    tw_pkg::cfg_t cfg_reg;
    tw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                tw_pkg::REG_LINE_HEIGHT: cfg_next.line_height = cfg_data[7:0];
                tw_pkg::REG_WRAP_WIDTH:  cfg_next.wrap_width  = cfg_data;
                tw_pkg::REG_QUERY_X:     cfg_next.query_x     = $signed(cfg_data);
                tw_pkg::REG_QUERY_Y:     cfg_next.query_y     = $signed(cfg_data);
                tw_pkg::REG_ORIGIN_X:    cfg_next.origin_x    = $signed(cfg_data);
                tw_pkg::REG_ORIGIN_Y:    cfg_next.origin_y    = $signed(cfg_data);
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_height <= tw_pkg::LINE_HEIGHT_RST;
            cfg_reg.wrap_width  <= '0;
            cfg_reg.query_x     <= '0;
            cfg_reg.query_y     <= '0;
            cfg_reg.origin_x    <= '0;
            cfg_reg.origin_y    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/tw_core.sv */
// Layout state and step logic: pen, line, extent, index and hit test.
// Depends on tw_pkg for cfg_t, item_t and result_t.
`timescale 1ns / 1ps

module tw_core
#(
    parameter int MAX_CHARS = 1024
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  tw_pkg::item_t   item,
    input  tw_pkg::cfg_t    cfg,
    output tw_pkg::result_t result
);

    localparam int IDX_W = $clog2(MAX_CHARS + 1);
    localparam int OUT_W = (IDX_W > tw_pkg::HIT_INDEX_W) ? IDX_W : tw_pkg::HIT_INDEX_W;
    localparam logic [IDX_W:0] MAX_EXT = (IDX_W + 1)'(MAX_CHARS);

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hFFFF : v[15:0];
    endfunction

    logic [15:0]      pen_x_reg, pen_x_next;
    logic [15:0]      line_y_reg, line_y_next;
    logic [15:0]      widest_reg, widest_next;
    logic [IDX_W-1:0] char_index_reg, char_index_next;
    logic             hit_done_reg, hit_done_next;
    logic [IDX_W-1:0] hit_pos_reg, hit_pos_next;

    logic signed [17:0] qx_s, qy_s;
    logic [IDX_W:0]     idx_inc;
    logic [IDX_W-1:0]   idx_next;
    logic               hd_a, hd_b, hd_c;
    logic [IDX_W-1:0]   hp_a, hp_b, hp_c;
    logic [15:0]        line_adv;
    logic [16:0]        pen_sum;
    logic               wrap, adv, adv_hit, glyph_hit, near;
    logic [15:0]        pen1, line1, widest1, pen2, widest2;
    logic [16:0]        line_lh;
    logic signed [17:0] diff;
    logic [IDX_W-1:0]   hit_sel;
    logic [OUT_W-1:0]   hit_wide;

    assign qx_s = {{2{cfg.query_x[15]}}, cfg.query_x};
    assign qy_s = {{2{cfg.query_y[15]}}, cfg.query_y};

    always_comb
    begin
        idx_inc  = {1'b0, char_index_reg} + {{IDX_W{1'b0}}, 1'b1};
        idx_next = (idx_inc > MAX_EXT) ? MAX_EXT[IDX_W-1:0] : idx_inc[IDX_W-1:0];

        // A query above the string resolves to index zero on the first open item.
        hd_a = hit_done_reg;
        hp_a = hit_pos_reg;
        if (!hd_a && cfg.query_y[15])
        begin
            hd_a = 1'b1;
            hp_a = '0;
        end

        line_adv = sat16({1'b0, line_y_reg} + {9'b0, cfg.line_height});
        pen_sum  = {1'b0, pen_x_reg} + {9'b0, item.glyph_width};
        wrap     = !item.is_newline && (cfg.wrap_width != '0) && (pen_x_reg != '0)
                   && (pen_sum > {1'b0, cfg.wrap_width});
        adv      = item.is_newline || wrap;

        pen1    = adv ? 16'd0 : pen_x_reg;
        line1   = adv ? line_adv : line_y_reg;
        widest1 = (adv && (pen_x_reg > widest_reg)) ? pen_x_reg : widest_reg;

        adv_hit = adv && !hd_a && ($signed({2'b0, line1}) > qy_s);
        hd_b    = hd_a || adv_hit;
        hp_b    = adv_hit ? char_index_reg : hp_a;

        pen2    = item.is_newline ? 16'd0 : sat16({1'b0, pen1} + {9'b0, item.glyph_width});
        widest2 = (!item.is_newline && (pen2 > widest1)) ? pen2 : widest1;
        line_lh = {1'b0, line1} + {9'b0, cfg.line_height};

        // The glyph hit picks the nearer edge of the glyph.
        diff      = $signed({2'b0, pen2}) - qx_s;
        near      = diff > $signed({11'b0, item.glyph_width[7:1]});
        glyph_hit = !item.is_newline && !hd_b && ($signed({2'b0, pen2}) > qx_s)
                    && ($signed({1'b0, line_lh}) > qy_s);
        hd_c      = hd_b || glyph_hit;
        hp_c      = glyph_hit ? (near ? char_index_reg : idx_next) : hp_b;

        hit_sel  = hd_c ? hp_c : idx_next;
        hit_wide = OUT_W'(hit_sel);

        result.glyph_valid   = !item.is_newline;
        result.glyph_x       = item.is_newline ? '0
                               : ({{2{cfg.origin_x[15]}}, cfg.origin_x} + $signed({2'b0, pen1}));
        result.glyph_y       = item.is_newline ? '0
                               : ({{2{cfg.origin_y[15]}}, cfg.origin_y} + $signed({2'b0, line1}));
        result.extent_width  = widest2;
        result.extent_height = sat16(line_lh);
        result.end_x         = pen2;
        result.hit_found     = hd_c;
        result.hit_index     = hit_wide[tw_pkg::HIT_INDEX_W-1:0];
        result.last_out      = item.last;

        pen_x_next      = pen_x_reg;
        line_y_next     = line_y_reg;
        widest_next     = widest_reg;
        char_index_next = char_index_reg;
        hit_done_next   = hit_done_reg;
        hit_pos_next    = hit_pos_reg;
        if (step_en)
        begin
            if (item.last)
            begin
                pen_x_next      = '0;
                line_y_next     = '0;
                widest_next     = '0;
                char_index_next = '0;
                hit_done_next   = 1'b0;
                hit_pos_next    = '0;
            end
            else
            begin
                pen_x_next      = pen2;
                line_y_next     = line1;
                widest_next     = widest2;
                char_index_next = idx_next;
                hit_done_next   = hd_c;
                hit_pos_next    = hp_c;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg      <= '0;
            line_y_reg     <= '0;
            widest_reg     <= '0;
            char_index_reg <= '0;
            hit_done_reg   <= 1'b0;
            hit_pos_reg    <= '0;
        end
        else
        begin
            pen_x_reg      <= pen_x_next;
            line_y_reg     <= line_y_next;
            widest_reg     <= widest_next;
            char_index_reg <= char_index_next;
            hit_done_reg   <= hit_done_next;
            hit_pos_reg    <= hit_pos_next;
        end
    end

endmodule
